// ===== src/double_ended_queue_assert.svh =====
// Assertion macros for the double-ended queue checker.
// All macros sample on clk and are disabled while arst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define DQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int CAPACITY  = 1024;
	localparam int WORD_BITS = 32;
	localparam int IDX_BITS  = $clog2(CAPACITY);
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);

	// fixed field widths
	localparam int KIND_BITS   = 3;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 11;

	// command kinds; unlisted codes act as query only
	localparam logic [KIND_BITS-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_QUERY      = 3'd4;

	// result status codes
	localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_POP_EMPTY = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_PUSH_FULL = 2'd2;
	localparam logic [STATUS_BITS-1:0] STATUS_RSVD      = 2'd3;

	typedef struct packed {
		logic [KIND_BITS-1:0]        kind;
		logic signed [WORD_BITS-1:0] value;
	} dq_cmd_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] popped_word;
		logic [STATUS_BITS-1:0]      status;
		logic [COUNT_BITS-1:0]       entry_count;
		logic                        is_empty;
		logic signed [WORD_BITS-1:0] front_word;
		logic signed [WORD_BITS-1:0] back_word;
	} dq_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture accepted command
		logic exec;   // update pointers, store, end caches
		logic fill;   // load end cache from store read data
		logic emit;   // load result register
	} dq_ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic need_read;  // pop leaves words: new end must be read
	} dq_stat_t;

endpackage

// ===== src/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Command sequencer and result-valid register of the double-ended queue.
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output dq_pkg::dq_ctrl_t ctrl,
	input  dq_pkg::dq_stat_t stat
);
	import dq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_FILL = 4'b0100,
		ST_DONE = 4'b1000
	} dq_state_t;

	dq_state_t state_q, state_d;
	logic      rsp_valid_q;

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctrl.load = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctrl.exec = 1'b1;
				state_d   = stat.need_read ? ST_FILL : ST_DONE;
			end
			ST_FILL: begin
				ctrl.fill = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				// wait for the result register to free up
				if (!rsp_valid_q || rsp_ready) begin
					ctrl.emit = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/dq_dpath.sv =====
// ----------------------------------------------------------------------------
// dq_dpath
// Ring store, head/count pointers, cached end words and result register.
// ----------------------------------------------------------------------------
module dq_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  dq_pkg::dq_cmd_t  cmd,
	output dq_pkg::dq_rsp_t  rsp,
	input  dq_pkg::dq_ctrl_t ctrl,
	output dq_pkg::dq_stat_t stat
);
	import dq_pkg::*;

	localparam int SUM_BITS = IDX_BITS + 1;

	// (base + offs) mod CAPACITY; caller must keep offs not above CAPACITY, the function does not enforce it
	function automatic logic [IDX_BITS-1:0] wrap_add(logic [IDX_BITS-1:0] base,
	                                                 logic [SUM_BITS-1:0] offs);
		logic [SUM_BITS-1:0] s;
		s = {1'b0, base} + offs;
		if (s >= SUM_BITS'(CAPACITY)) begin
			s = s - SUM_BITS'(CAPACITY);
		end
		return s[IDX_BITS-1:0];
	endfunction

	logic [KIND_BITS-1:0]   kind_q;
	logic [WORD_BITS-1:0]   value_q;
	logic [IDX_BITS-1:0]    head_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [WORD_BITS-1:0]   front_q, back_q, popped_q;
	logic [STATUS_BITS-1:0] status_q;
	logic                   fill_front_q;
	dq_rsp_t                rsp_q;

	logic is_push, is_pop, full, empty;
	logic [IDX_BITS-1:0] head_dec, head_inc, tail_addr, prev_back;
	logic                ram_we, ram_re;
	logic [IDX_BITS-1:0] ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	assign is_push = (kind_q == KIND_PUSH_FRONT) || (kind_q == KIND_PUSH_BACK);
	assign is_pop  = (kind_q == KIND_POP_FRONT) || (kind_q == KIND_POP_BACK);
	assign full    = (count_q == CNT_BITS'(CAPACITY));
	assign empty   = (count_q == '0);

	assign head_dec  = (head_q == '0) ? IDX_BITS'(CAPACITY - 1) : head_q - 1'b1;
	assign head_inc  = (head_q == IDX_BITS'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
	assign tail_addr = wrap_add(head_q, SUM_BITS'(count_q));
	assign prev_back = wrap_add(head_q, SUM_BITS'(count_q - CNT_BITS'(2)));

	assign stat.need_read = is_pop && (count_q > CNT_BITS'(1));

	assign ram_we    = ctrl.exec && is_push && !full;
	assign ram_waddr = (kind_q == KIND_PUSH_FRONT) ? head_dec : tail_addr;
	assign ram_re    = ctrl.exec && stat.need_read;
	assign ram_raddr = (kind_q == KIND_POP_FRONT) ? head_inc : prev_back;

	dq_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctrl.exec) begin
			if (is_push && !full) begin
				count_q <= count_q + 1'b1;
				if (kind_q == KIND_PUSH_FRONT) begin
					head_q <= head_dec;
				end
			end else if (is_pop && !empty) begin
				count_q <= count_q - 1'b1;
				if (kind_q == KIND_POP_FRONT) begin
					head_q <= head_inc;
				end
			end
		end
	end

	// command capture, end caches, result
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			kind_q  <= cmd.kind;
			value_q <= cmd.value;
		end
		if (ctrl.exec) begin
			popped_q     <= '1;
			status_q     <= STATUS_OK;
			fill_front_q <= (kind_q == KIND_POP_FRONT);
			if (is_push) begin
				if (full) begin
					status_q <= STATUS_PUSH_FULL;
				end else if (kind_q == KIND_PUSH_FRONT) begin
					front_q <= value_q;
					if (empty) begin
						back_q <= value_q;
					end
				end else begin
					back_q <= value_q;
					if (empty) begin
						front_q <= value_q;
					end
				end
			end else if (is_pop) begin
				if (empty) begin
					status_q <= STATUS_POP_EMPTY;
				end else if (kind_q == KIND_POP_FRONT) begin
					popped_q <= front_q;
				end else begin
					popped_q <= back_q;
				end
			end
		end
		if (ctrl.fill) begin
			if (fill_front_q) begin
				front_q <= ram_rdata;
			end else begin
				back_q <= ram_rdata;
			end
		end
		if (ctrl.emit) begin
			rsp_q.popped_word <= popped_q;
			rsp_q.status      <= status_q;
			rsp_q.entry_count <= COUNT_BITS'(count_q);
			rsp_q.is_empty    <= empty;
			rsp_q.front_word  <= empty ? '1 : front_q;
			rsp_q.back_word   <= empty ? '1 : back_q;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words in a ring store.
// ----------------------------------------------------------------------------
//
//   channel | signals                      | payload
//   --------+------------------------------+---------------------------------
//   command | cmd_valid / cmd_ready / cmd  | kind, value
//   result  | rsp_valid / rsp_ready / rsp  | popped_word, status, entry_count,
//           |                              | is_empty, front_word, back_word
//
// One command is in work at a time. A push, a query, a failed operation or a
// pop that empties the queue goes through accept, execute and emit; a pop that
// leaves words adds a fill step before emit, the registered read of the
// store's single read port that fetches the new end word. Reset clears head,
// count, state and result-valid flag; the store needs no clearing pass.
// A pending result stalls the sequencer only in its final step, so the next
// command is accepted and worked while the previous result waits.
//
module double_ended_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  dq_pkg::dq_cmd_t cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output dq_pkg::dq_rsp_t rsp
);
	import dq_pkg::*;

	// sequencing commands and datapath status
	dq_ctrl_t ctrl;
	dq_stat_t stat;

	// controller: one-hot sequencer plus result-valid flag
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctrl      (ctrl),
		.stat      (stat)
	);

	// datapath: store, pointers, front/back caches, result register
	dq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.ctrl   (ctrl),
		.stat   (stat)
	);

endmodule

// ===== src/dq_checker.sv =====
// ----------------------------------------------------------------------------
// dq_checker
// Port-level assertions for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module dq_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cmd_valid,
	input logic            cmd_ready,
	input dq_pkg::dq_cmd_t cmd,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input dq_pkg::dq_rsp_t rsp
);
	import dq_pkg::*;

	// stalled result holds
	`DQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")

	// empty flag tracks count, empty ends read as all ones
	`DQ_ASSERT_IMPL(a_empty_ends, rsp_valid && rsp.is_empty, rsp.entry_count == '0 && rsp.front_word == '1 && rsp.back_word == '1, "empty result with stale count or ends")

	// failed pop leaves an empty queue and returns all ones
	`DQ_ASSERT_IMPL(a_pop_empty, rsp_valid && rsp.status == STATUS_POP_EMPTY, rsp.is_empty && rsp.popped_word == '1, "bad pop-on-empty result")

	// dropped push only when full
	`DQ_ASSERT_IMPL(a_push_full, rsp_valid && rsp.status == STATUS_PUSH_FULL, rsp.entry_count == COUNT_BITS'(CAPACITY) && rsp.popped_word == '1, "push dropped below capacity")

	// count bounded, reserved status never shown
	`DQ_ASSERT_IMPL(a_count_bound, rsp_valid, rsp.entry_count <= COUNT_BITS'(CAPACITY) && rsp.status != STATUS_RSVD && rsp.is_empty == (rsp.entry_count == '0), "count or status out of range")

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
